[rtl/orr_pkg.sv]
// Package for the priority-ordered ready ring.
// Holds sizes, command and status codes and the controller/datapath interface
// types. No dependencies.
package orr_pkg;

  // Sizes
  localparam int MAX_THREADS = 16;
  localparam int ID_BITS     = 8;
  localparam int PRIO_BITS   = 8;
  localparam int IDX_W       = $clog2(MAX_THREADS);
  localparam int CNT_W       = $clog2(MAX_THREADS + 1);

  // Command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_SCHED  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_PRESENT   = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture the input item
    logic compare;  // register id-hit and priority vectors
    logic locate;   // register positions from the vectors
    logic execute;  // apply the command, load the result register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_hold;  // result register full and stalled
  } dp_stat_t;

endpackage

[rtl/orr_ctrl.sv]
// Controller for the priority-ordered ready ring.
// Sequences load, compare, locate and execute steps. Uses orr_pkg.
module orr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  orr_pkg::dp_stat_t dp_stat,
  output orr_pkg::dp_cmd_t  dp_cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_POS  = 2'd2;
  localparam logic [1:0] S_EXEC = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.load = 1'b1;
          state_next  = S_CMP;
        end
      end
      S_CMP: begin
        dp_cmd.compare = 1'b1;
        state_next     = S_POS;
      end
      S_POS: begin
        dp_cmd.locate = 1'b1;
        state_next    = S_EXEC;
      end
      S_EXEC: begin
        if (!dp_stat.out_hold) begin
          dp_cmd.execute = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/orr_datapath.sv]
// Datapath for the priority-ordered ready ring.
// Slot rows, cursor, current thread and result register. Uses orr_pkg.
module orr_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  orr_pkg::dp_cmd_t              dp_cmd,
  output orr_pkg::dp_stat_t             dp_stat,
  input  logic [1:0]                    command,
  input  logic [orr_pkg::ID_BITS-1:0]   thread_id,
  input  logic [orr_pkg::PRIO_BITS-1:0] priority_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic [orr_pkg::ID_BITS-1:0]   current_id,
  output logic                          current_valid
);

  localparam int N = orr_pkg::MAX_THREADS;

  // Slot rows; entries at or above entry_count are don't-care
  logic [orr_pkg::ID_BITS-1:0]   slot_thread   [N];
  logic [orr_pkg::PRIO_BITS-1:0] slot_priority [N];
  logic [orr_pkg::ID_BITS-1:0]   slot_thread_next   [N];
  logic [orr_pkg::PRIO_BITS-1:0] slot_priority_next [N];

  logic [orr_pkg::CNT_W-1:0]     entry_count, entry_count_next;
  logic [orr_pkg::IDX_W-1:0]     cursor_position, cursor_position_next;
  logic                          cursor_valid, cursor_valid_next;
  logic [orr_pkg::ID_BITS-1:0]   current_thread, current_thread_next;
  logic                          current_present, current_present_next;
  logic [1:0]                    status_next;

  // Captured item
  logic [1:0]                    cmd_q;
  logic [orr_pkg::ID_BITS-1:0]   id_q;
  logic [orr_pkg::PRIO_BITS-1:0] prio_q;

  // Search results
  logic [N-1:0]                  hit_vec, le_vec;
  logic [N-1:0]                  hit_vec_next, le_vec_next;
  logic                          found;
  logic [orr_pkg::IDX_W-1:0]     find_pos, find_pos_next;
  logic [orr_pkg::CNT_W-1:0]     ins_pos, ins_pos_next;

  logic [orr_pkg::CNT_W-1:0]     cnt_dec;
  logic [orr_pkg::IDX_W-1:0]     sched_next;

  assign dp_stat.out_hold = out_valid & out_stall;

  // Parallel compare of every live slot
  always_comb begin
    for (int i = 0; i < N; i++) begin
      hit_vec_next[i] = (orr_pkg::CNT_W'(i) < entry_count) && (slot_thread[i] == id_q);
      le_vec_next[i]  = (orr_pkg::CNT_W'(i) < entry_count) && (slot_priority[i] <= prio_q);
    end
  end

  // Hit index (ids are unique) and insert position (sorted, so a prefix count)
  always_comb begin
    find_pos_next = '0;
    ins_pos_next  = '0;
    for (int i = 0; i < N; i++) begin
      if (hit_vec[i]) find_pos_next = find_pos_next | orr_pkg::IDX_W'(i);
      ins_pos_next = ins_pos_next + orr_pkg::CNT_W'(le_vec[i]);
    end
  end

  assign cnt_dec = entry_count - orr_pkg::CNT_W'(1);

  // Round-robin successor of the cursor
  always_comb begin
    if ((orr_pkg::CNT_W'(cursor_position) + orr_pkg::CNT_W'(1)) >= entry_count) begin
      sched_next = '0;
    end else begin
      sched_next = cursor_position + orr_pkg::IDX_W'(1);
    end
  end

  // Command execution
  always_comb begin
    slot_thread_next     = slot_thread;
    slot_priority_next   = slot_priority;
    entry_count_next     = entry_count;
    cursor_position_next = cursor_position;
    cursor_valid_next    = cursor_valid;
    current_thread_next  = current_thread;
    current_present_next = current_present;
    status_next          = orr_pkg::ST_OK;
    case (cmd_q)
      orr_pkg::CMD_ADD: begin
        if (found) begin
          status_next = orr_pkg::ST_PRESENT;
        end else if (entry_count == orr_pkg::CNT_W'(N)) begin
          status_next = orr_pkg::ST_FULL;
        end else begin
          for (int i = 1; i < N; i++) begin
            if (orr_pkg::CNT_W'(i) > ins_pos) begin
              slot_thread_next[i]   = slot_thread[i-1];
              slot_priority_next[i] = slot_priority[i-1];
            end
          end
          slot_thread_next[ins_pos[orr_pkg::IDX_W-1:0]]   = id_q;
          slot_priority_next[ins_pos[orr_pkg::IDX_W-1:0]] = prio_q;
          entry_count_next = entry_count + orr_pkg::CNT_W'(1);
          if (cursor_valid && (ins_pos <= orr_pkg::CNT_W'(cursor_position))) begin
            cursor_position_next = cursor_position + orr_pkg::IDX_W'(1);
          end
        end
      end
      orr_pkg::CMD_REMOVE: begin
        if (!found) begin
          status_next = orr_pkg::ST_NOT_FOUND;
        end else begin
          for (int i = 0; i < N - 1; i++) begin
            if (orr_pkg::IDX_W'(i) >= find_pos) begin
              slot_thread_next[i]   = slot_thread[i+1];
              slot_priority_next[i] = slot_priority[i+1];
            end
          end
          entry_count_next = cnt_dec;
          if (current_present && (current_thread == id_q)) begin
            current_present_next = 1'b0;
            current_thread_next  = '0;
          end
          if (cnt_dec == '0) begin
            cursor_valid_next    = 1'b0;
            cursor_position_next = '0;
          end else if (cursor_valid) begin
            if (find_pos < cursor_position) begin
              cursor_position_next = cursor_position - orr_pkg::IDX_W'(1);
            end else if (find_pos == cursor_position) begin
              cursor_position_next = (find_pos == '0) ?
                  (cnt_dec[orr_pkg::IDX_W-1:0] - orr_pkg::IDX_W'(1)) :
                  (find_pos - orr_pkg::IDX_W'(1));
            end
          end
        end
      end
      orr_pkg::CMD_SCHED: begin
        if (entry_count == '0) begin
          cursor_valid_next    = 1'b0;
          cursor_position_next = '0;
          current_present_next = 1'b0;
          current_thread_next  = '0;
        end else if (!cursor_valid ||
                     (orr_pkg::CNT_W'(cursor_position) >= entry_count)) begin
          cursor_position_next = '0;
          cursor_valid_next    = 1'b1;
          current_thread_next  = slot_thread[0];
          current_present_next = 1'b1;
        end else begin
          cursor_position_next = sched_next;
          current_thread_next  = slot_thread[sched_next];
          current_present_next = 1'b1;
        end
      end
      default: status_next = orr_pkg::ST_OK;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count     <= '0;
      cursor_position <= '0;
      cursor_valid    <= 1'b0;
      current_thread  <= '0;
      current_present <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (dp_cmd.execute) begin
        entry_count     <= entry_count_next;
        cursor_position <= cursor_position_next;
        cursor_valid    <= cursor_valid_next;
        current_thread  <= current_thread_next;
        current_present <= current_present_next;
      end
      out_valid <= dp_cmd.execute | (out_valid & out_stall);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_q  <= command;
      id_q   <= thread_id;
      prio_q <= priority_req;
    end
    if (dp_cmd.compare) begin
      hit_vec <= hit_vec_next;
      le_vec  <= le_vec_next;
    end
    if (dp_cmd.locate) begin
      found    <= |hit_vec;
      find_pos <= find_pos_next;
      ins_pos  <= ins_pos_next;
    end
    if (dp_cmd.execute) begin
      slot_thread   <= slot_thread_next;
      slot_priority <= slot_priority_next;
      status        <= status_next;
      current_id    <= current_present_next ? current_thread_next : '0;
      current_valid <= current_present_next;
    end
  end

endmodule

[rtl/priority_ordered_ready_ring_top.sv]
// Top level of the priority-ordered ready ring.
// Instantiates orr_ctrl and orr_datapath. Uses orr_pkg.
//
//   channel | direction | handshake           | fields
//   --------+-----------+---------------------+-----------------------------------
//   in      | to block  | in_valid / in_stall | command, thread_id, priority_req
//   out     | from block| out_valid/out_stall | status, current_id, current_valid
//
// Every item holds the sequencer from capture at acceptance through a parallel
// compare over the 16 slots and a position encode to the update of the rows.
// The result is registered by that update; the next item is taken back in idle.
// One item is in work at a time; the next is taken as soon as the sequencer
// is back in idle, even while the previous result waits in the output register.
// A stalled output holds the sequencer in its execute step.
// Synchronous reset empties the list and clears the cursor and current thread.
module priority_ordered_ready_ring_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    command,
  input  logic [orr_pkg::ID_BITS-1:0]   thread_id,
  input  logic [orr_pkg::PRIO_BITS-1:0] priority_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic [orr_pkg::ID_BITS-1:0]   current_id,
  output logic                          current_valid
);

  orr_pkg::dp_cmd_t  dp_cmd;
  orr_pkg::dp_stat_t dp_stat;

  orr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .dp_stat  (dp_stat),
    .dp_cmd   (dp_cmd)
  );

  orr_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .dp_cmd        (dp_cmd),
    .dp_stat       (dp_stat),
    .command       (command),
    .thread_id     (thread_id),
    .priority_req  (priority_req),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .current_id    (current_id),
    .current_valid (current_valid)
  );

endmodule

[rtl/orr_checker.sv]
// Port checker for the priority-ordered ready ring, bound to the top level.
// Uses orr_pkg for widths only.
module orr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    status,
  input logic [orr_pkg::ID_BITS-1:0]   current_id,
  input logic                          current_valid
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(status) && $stable(current_id) &&
                               $stable(current_valid))
    else $error("stalled result changed");

  // No current thread reports id zero
  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !current_valid |-> current_id == '0)
    else $error("current_id nonzero without current thread");

  // One item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

endmodule

bind priority_ordered_ready_ring_top orr_checker u_orr_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .current_id    (current_id),
  .current_valid (current_valid)
);

[dv/tb_priority_ordered_ready_ring_top.sv]
// Self-checking testbench for priority_ordered_ready_ring_top: directed and random
// add/remove/schedule items, checked against an in-bench model of the sorted ring.
// Depends on orr_pkg and the RTL of priority_ordered_ready_ring_top only.
module tb_priority_ordered_ready_ring_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Command 3 is not a named code in the package: the block reports state only
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int RANDOM_ITEMS   = 1600;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 10;
  localparam int ID_POOL_SIZE   = 24;

  typedef struct {
    logic [1:0]                    cmd;
    logic [orr_pkg::ID_BITS-1:0]   id;
    logic [orr_pkg::PRIO_BITS-1:0] prio;
    bit                            drain_first;  // hold off until every reply is back
  } ring_cmd_t;

  typedef struct {
    logic [1:0]                  status;
    logic [orr_pkg::ID_BITS-1:0] current_id;
    logic                        current_valid;
  } ring_reply_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [1:0]                    command = orr_pkg::CMD_ADD;
  logic [orr_pkg::ID_BITS-1:0]   thread_id = '0;
  logic [orr_pkg::PRIO_BITS-1:0] priority_req = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [1:0]                    status;
  logic [orr_pkg::ID_BITS-1:0]   current_id;
  logic                          current_valid;

  // Stimulus, expectations and counters
  ring_cmd_t   pending_items[$];
  ring_reply_t expected_replies[$];
  ring_cmd_t   item_on_bus;
  int          total_items;
  int          items_accepted = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          sender_idle_pct = 23;
  int          receiver_idle_pct = 53;
  logic [orr_pkg::ID_BITS-1:0] id_pool [ID_POOL_SIZE];

  // Model of the ready ring
  logic [orr_pkg::ID_BITS-1:0]   ring_id   [orr_pkg::MAX_THREADS];
  logic [orr_pkg::PRIO_BITS-1:0] ring_prio [orr_pkg::MAX_THREADS];
  int                            ring_count = 0;
  int                            cursor_pos = 0;
  bit                            cursor_on = 1'b0;
  logic [orr_pkg::ID_BITS-1:0]   cur_thread = '0;
  bit                            cur_present = 1'b0;

  priority_ordered_ready_ring_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .thread_id    (thread_id),
    .priority_req (priority_req),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .current_id   (current_id),
    .current_valid(current_valid)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one item to the ring model and queue the reply it must produce
  task automatic update_ready_list(input ring_cmd_t it);
    ring_reply_t r;
    int hit;
    int pos;
    r.status = orr_pkg::ST_OK;
    hit = -1;
    for (int i = 0; i < ring_count; i++)
      if (hit < 0 && ring_id[i] == it.id) hit = i;
    case (it.cmd)
      orr_pkg::CMD_ADD: begin
        if (hit >= 0) begin
          r.status = orr_pkg::ST_PRESENT;
        end else if (ring_count >= orr_pkg::MAX_THREADS) begin
          r.status = orr_pkg::ST_FULL;
        end else begin
          // new entry goes after every entry of equal or lower priority value
          pos = 0;
          while (pos < ring_count && ring_prio[pos] <= it.prio) pos++;
          for (int i = ring_count; i > pos; i--) begin
            ring_id[i]   = ring_id[i-1];
            ring_prio[i] = ring_prio[i-1];
          end
          ring_id[pos]   = it.id;
          ring_prio[pos] = it.prio;
          ring_count++;
          if (cursor_on && pos <= cursor_pos) cursor_pos++;
        end
      end
      orr_pkg::CMD_REMOVE: begin
        if (hit < 0) begin
          r.status = orr_pkg::ST_NOT_FOUND;
        end else begin
          for (int i = hit; i + 1 < ring_count; i++) begin
            ring_id[i]   = ring_id[i+1];
            ring_prio[i] = ring_prio[i+1];
          end
          ring_count--;
          if (cur_present && cur_thread == it.id) begin
            cur_present = 1'b0;
            cur_thread  = '0;
          end
          if (ring_count == 0) begin
            cursor_on  = 1'b0;
            cursor_pos = 0;
          end else if (cursor_on) begin
            // removal at the cursor steps back so the successor comes next
            if (hit < cursor_pos) cursor_pos--;
            else if (hit == cursor_pos) cursor_pos = (hit == 0) ? ring_count - 1 : hit - 1;
          end
        end
      end
      orr_pkg::CMD_SCHED: begin
        if (ring_count == 0) begin
          cursor_on   = 1'b0;
          cursor_pos  = 0;
          cur_present = 1'b0;
          cur_thread  = '0;
        end else begin
          if (!cursor_on || cursor_pos >= ring_count) begin
            cursor_pos = 0;
            cursor_on  = 1'b1;
          end else begin
            cursor_pos++;
            if (cursor_pos >= ring_count) cursor_pos = 0;
          end
          cur_thread  = ring_id[cursor_pos];
          cur_present = 1'b1;
        end
      end
      default: ;
    endcase
    r.current_id    = cur_present ? cur_thread : '0;
    r.current_valid = cur_present;
    expected_replies.push_back(r);
  endtask

  task automatic push_item(input logic [1:0] cmd, input logic [orr_pkg::ID_BITS-1:0] id,
                           input logic [orr_pkg::PRIO_BITS-1:0] prio,
                           input bit drain_first);
    ring_cmd_t it;
    it.cmd         = cmd;
    it.id          = id;
    it.prio        = prio;
    it.drain_first = drain_first;
    pending_items.push_back(it);
  endtask

  // Mostly ids from a small pool so the ring fills and hits, sometimes any id
  function automatic logic [orr_pkg::ID_BITS-1:0] pick_id();
    if ($urandom_range(0, 9) == 0) return orr_pkg::ID_BITS'($urandom_range(0, 255));
    return id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
  endfunction

  // Small priority values give many ties
  function automatic logic [orr_pkg::PRIO_BITS-1:0] pick_prio();
    if ($urandom_range(0, 1) == 0) return orr_pkg::PRIO_BITS'($urandom_range(0, 7));
    return orr_pkg::PRIO_BITS'($urandom_range(0, 255));
  endfunction

  // Driver: present items from the pending queue, idle at random
  always @(posedge clk) begin : drive_items
    bit present_next;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        update_ready_list(item_on_bus);
        items_accepted++;
        if (items_accepted < total_items / 3) begin
          sender_idle_pct   = 23;
          receiver_idle_pct = 53;
        end else if (items_accepted < 2 * total_items / 3) begin
          sender_idle_pct   = 53;
          receiver_idle_pct = 23;
        end else begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      end
      if (!in_valid || !in_stall) begin
        present_next = pending_items.size() != 0 &&
                       !(pending_items[0].drain_first && expected_replies.size() != 0) &&
                       $urandom_range(0, 99) >= sender_idle_pct;
        if (present_next) begin
          item_on_bus = pending_items.pop_front();
          command      <= item_on_bus.cmd;
          thread_id    <= item_on_bus.id;
          priority_req <= item_on_bus.prio;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each reply with the oldest expectation, stall at random
  always @(posedge clk) begin : check_replies
    ring_reply_t exp_r;
    if (!rst) begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (expected_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected reply: status %0d id %0h valid %0b",
                     status, current_id, current_valid);
        end else begin
          exp_r = expected_replies.pop_front();
          if (status !== exp_r.status || current_id !== exp_r.current_id ||
              current_valid !== exp_r.current_valid) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected status %0d id %0h valid %0b, got %0d %0h %0b",
                       exp_r.status, exp_r.current_id, exp_r.current_valid,
                       status, current_id, current_valid);
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end
  end

  // Watchdog on cycles where neither channel moves an item
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL priority_ordered_ready_ring_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus and end of run
  initial begin
    int kind;
    int roll;
    for (int i = 0; i < ID_POOL_SIZE; i++)
      id_pool[i] = orr_pkg::ID_BITS'($urandom_range(0, 255));

    // Directed: empty cases, ties, duplicate, inserts and removals around the cursor
    push_item(orr_pkg::CMD_SCHED,  8'h00, 8'h00, 1'b0);  // schedule on empty list
    push_item(orr_pkg::CMD_REMOVE, 8'h3C, 8'h00, 1'b0);  // unknown id
    push_item(CMD_NOP,             8'hFF, 8'hFF, 1'b0);
    push_item(orr_pkg::CMD_ADD,    8'hFF, 8'hFF, 1'b0);
    push_item(orr_pkg::CMD_ADD,    8'h00, 8'h00, 1'b0);
    push_item(orr_pkg::CMD_ADD,    8'hAA, 8'h80, 1'b0);
    push_item(orr_pkg::CMD_ADD,    8'h55, 8'h80, 1'b0);  // equal priority keeps arrival order
    push_item(orr_pkg::CMD_ADD,    8'hAA, 8'h10, 1'b0);  // duplicate
    push_item(orr_pkg::CMD_SCHED,  8'h12, 8'h34, 1'b0);
    push_item(orr_pkg::CMD_SCHED,  8'hED, 8'hCB, 1'b0);
    push_item(orr_pkg::CMD_ADD,    8'h01, 8'h00, 1'b0);  // insert before the cursor
    push_item(orr_pkg::CMD_SCHED,  8'h00, 8'h00, 1'b0);
    push_item(orr_pkg::CMD_REMOVE, 8'h55, 8'h00, 1'b0);  // removal at the cursor, current too
    push_item(CMD_NOP,             8'h00, 8'h00, 1'b0);
    push_item(orr_pkg::CMD_SCHED,  8'h00, 8'h00, 1'b0);
    push_item(orr_pkg::CMD_SCHED,  8'h00, 8'h00, 1'b0);  // wrap from tail to head
    push_item(orr_pkg::CMD_REMOVE, 8'hFF, 8'h00, 1'b0);
    push_item(orr_pkg::CMD_REMOVE, 8'h00, 8'h00, 1'b0);  // removal of the head under the cursor
    push_item(orr_pkg::CMD_REMOVE, 8'h01, 8'h00, 1'b0);
    push_item(orr_pkg::CMD_REMOVE, 8'hAA, 8'h00, 1'b0);  // list empties
    push_item(orr_pkg::CMD_SCHED,  8'h00, 8'h00, 1'b0);
    push_item(orr_pkg::CMD_REMOVE, 8'hAA, 8'h00, 1'b0);

    // Random bursts: fill runs reach a full list, drain runs empty it
    total_items = pending_items.size() + RANDOM_ITEMS;
    while (pending_items.size() < total_items) begin
      kind = $urandom_range(0, 9);
      for (int n = 0; n < 20 && pending_items.size() < total_items; n++) begin
        roll = $urandom_range(0, 99);
        if (kind <= 2)
          roll = (roll < 75) ? 0 : 60;
        else if (kind <= 4)
          roll = (roll < 75) ? 35 : 60;
        case (1'b1)
          roll < 35: push_item(orr_pkg::CMD_ADD, pick_id(), pick_prio(), 1'b0);
          roll < 60: push_item(orr_pkg::CMD_REMOVE, pick_id(), pick_prio(), 1'b0);
          roll < 95: push_item(orr_pkg::CMD_SCHED,
                               orr_pkg::ID_BITS'($urandom_range(0, 255)),
                               pick_prio(), 1'b0);
          default:   push_item(CMD_NOP, orr_pkg::ID_BITS'($urandom_range(0, 255)),
                               pick_prio(), 1'b0);
        endcase
      end
    end
    pending_items[total_items / 2].drain_first = 1'b1;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || in_valid || expected_replies.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_replies.size() == 0)
      $display("PASS priority_ordered_ready_ring_top");
    else
      $display("FAIL priority_ordered_ready_ring_top");
    $finish;
  end

endmodule
